### rtl/bbc_pkg.sv
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  localparam logic [1:0] TYPE_ROUND  = 2'd0;
  localparam logic [1:0] TYPE_SQUARE = 2'd1;
  localparam logic [1:0] TYPE_CURLY  = 2'd2;

  localparam logic [1:0] KIND_OK    = 2'd0;
  localparam logic [1:0] KIND_FAIL  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_OPEN  = 2'd3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_EOL   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] btype;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

### rtl/bbc_ram.sv
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/bbc_front.sv
module bbc_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char_code,
  input  logic          in_end_of_line,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output bbc_pkg::cmd_t cmd
);

  always_comb begin
    cmd.op    = bbc_pkg::OP_NONE;
    cmd.btype = bbc_pkg::TYPE_ROUND;
    if (in_end_of_line) begin
      cmd.op = bbc_pkg::OP_EOL;
    end else begin
      case (in_char_code)
        bbc_pkg::CH_OPEN_ROUND: begin
          cmd.op    = bbc_pkg::OP_PUSH;
          cmd.btype = bbc_pkg::TYPE_ROUND;
        end
        bbc_pkg::CH_OPEN_SQUARE: begin
          cmd.op    = bbc_pkg::OP_PUSH;
          cmd.btype = bbc_pkg::TYPE_SQUARE;
        end
        bbc_pkg::CH_OPEN_CURLY: begin
          cmd.op    = bbc_pkg::OP_PUSH;
          cmd.btype = bbc_pkg::TYPE_CURLY;
        end
        bbc_pkg::CH_CLOSE_ROUND: begin
          cmd.op    = bbc_pkg::OP_CLOSE;
          cmd.btype = bbc_pkg::TYPE_ROUND;
        end
        bbc_pkg::CH_CLOSE_SQUARE: begin
          cmd.op    = bbc_pkg::OP_CLOSE;
          cmd.btype = bbc_pkg::TYPE_SQUARE;
        end
        bbc_pkg::CH_CLOSE_CURLY: begin
          cmd.op    = bbc_pkg::OP_CLOSE;
          cmd.btype = bbc_pkg::TYPE_CURLY;
        end
        default: begin
          cmd.op = bbc_pkg::OP_NONE;
        end
      endcase
    end
  end

  // other characters are taken and dropped here
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && (cmd.op != bbc_pkg::OP_NONE);

endmodule

### rtl/bbc_fifo.sv
module bbc_fifo #(
  parameter int DEPTH = bbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbc_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output bbc_pkg::cmd_t out_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bbc_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          push, pop;

  assign in_ready  = (fill_r != CW'(DEPTH));
  assign out_valid = (fill_r != '0);
  assign out_cmd   = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

### rtl/bbc_back.sv
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bbc_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_report_kind,
  output logic [1:0]    out_bracket_type,
  output logic          out_last_result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          success_r, success_nxt;
  logic [1:0]    top_r, top_nxt;
  logic          top_ram_r, top_ram_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [1:0]    btype_r, btype_nxt;
  logic          last_r, last_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0]    rd_data;
  logic [1:0]    top;
  logic [CW-1:0] count_m2;
  logic          out_free;
  logic          do_pop;

  // top of stack lives in a register after a push, in the ram read port after a pop
  assign top      = top_ram_r ? rd_data : top_r;
  assign count_m2 = count_r - CW'(2);
  assign rd_addr  = count_m2[AW-1:0];
  assign wr_addr  = count_r[AW-1:0];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    success_nxt   = success_r;
    top_nxt       = top_r;
    top_ram_nxt   = top_ram_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    btype_nxt     = btype_r;
    last_nxt      = last_r;
    cmd_ready     = 1'b0;
    wr_en         = 1'b0;
    do_pop        = 1'b0;

    case (state_r)
      ST_RUN: begin
        case (cmd.op)
          bbc_pkg::OP_PUSH: begin
            cmd_ready = 1'b1;
            if (cmd_valid && (count_r != CW'(STACK_DEPTH))) begin
              wr_en       = 1'b1;
              count_nxt   = count_r + CW'(1);
              top_nxt     = cmd.btype;
              top_ram_nxt = 1'b0;
            end
          end
          bbc_pkg::OP_CLOSE: begin
            if (count_r != '0) begin
              cmd_ready = 1'b1;
              if (cmd_valid) begin
                do_pop = 1'b1;
                if (top != cmd.btype) begin
                  success_nxt = 1'b0;
                end
              end
            end else begin
              cmd_ready = out_free;
              if (cmd_valid && out_free) begin
                out_valid_nxt = 1'b1;
                kind_nxt      = bbc_pkg::KIND_CLOSE;
                btype_nxt     = cmd.btype;
                last_nxt      = 1'b1;
                success_nxt   = 1'b0;
              end
            end
          end
          bbc_pkg::OP_EOL: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
              out_valid_nxt = 1'b1;
              btype_nxt     = bbc_pkg::TYPE_ROUND;
              success_nxt   = 1'b1;
              if (success_r && (count_r == '0)) begin
                kind_nxt = bbc_pkg::KIND_OK;
                last_nxt = 1'b1;
              end else begin
                kind_nxt = bbc_pkg::KIND_FAIL;
                last_nxt = (count_r == '0);
                if (count_r != '0) begin
                  state_nxt = ST_DRAIN;
                end
              end
            end
          end
          default: begin
            cmd_ready = 1'b1;
          end
        endcase
      end
      ST_DRAIN: begin
        // one unmatched open per cycle while the output is free, top first
        if (out_free) begin
          do_pop        = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = bbc_pkg::KIND_OPEN;
          btype_nxt     = top;
          last_nxt      = (count_r == CW'(1));
          if (count_r == CW'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    if (do_pop) begin
      count_nxt   = count_r - CW'(1);
      top_ram_nxt = 1'b1;
    end
  end

  assign rd_en = do_pop && (count_r > CW'(1));

  bbc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(cmd.btype),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      success_r   <= 1'b1;
      top_ram_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      success_r   <= success_nxt;
      top_ram_r   <= top_ram_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    kind_r  <= kind_nxt;
    btype_r <= btype_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_report_kind  = kind_r;
  assign out_bracket_type = btype_r;
  assign out_last_result  = last_r;

endmodule

### rtl/bracket_balance_checker.sv
// a result passes the command queue and is registered at the back end output,
// and may first wait in the queue behind earlier commands
// one character per cycle while the queue has room; end of line gives the line report,
// then one per stacked open, those under the top read from the stack ram read port
// a 2-entry command queue lets input transfers continue while results wait
// reset: rst_n synchronous active low empties the queue and stack, sets success
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = bbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_report_kind,
  output logic [1:0] out_bracket_type,
  output logic       out_last_result
);

  bbc_pkg::cmd_t front_cmd, queue_cmd;
  logic          front_valid, front_ready;
  logic          queue_valid, queue_ready;

  bbc_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_end_of_line(in_end_of_line),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  bbc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(queue_valid),
    .out_ready(queue_ready),
    .out_cmd  (queue_cmd)
  );

  bbc_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (queue_valid),
    .cmd_ready       (queue_ready),
    .cmd             (queue_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_report_kind (out_report_kind),
    .out_bracket_type(out_bracket_type),
    .out_last_result (out_last_result)
  );

endmodule

### rtl/bbc_checker.sv
module bbc_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_report_kind,
  input logic [1:0] out_bracket_type,
  input logic       out_last_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_report_kind)
      && $stable(out_bracket_type) && $stable(out_last_result))
    else $error("result changed while stalled");

  // a balanced line is always the only result of its item
  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == bbc_pkg::KIND_OK) |-> out_last_result)
    else $error("balanced report not marked last");

  // line reports carry no bracket type
  a_line_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_report_kind == bbc_pkg::KIND_OK)
      || (out_report_kind == bbc_pkg::KIND_FAIL))
      |-> (out_bracket_type == bbc_pkg::TYPE_ROUND))
    else $error("line report with nonzero type");

  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == bbc_pkg::KIND_CLOSE) |-> out_last_result)
    else $error("unmatched close not marked last");

  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bracket_type != 2'd3))
    else $error("bracket type out of range");

endmodule

bind bracket_balance_checker bbc_assertions u_bbc_assertions (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_report_kind (out_report_kind),
  .out_bracket_type(out_bracket_type),
  .out_last_result (out_last_result)
);

### verif/bbc_checker.sv
`timescale 1ns / 100ps
module bbc_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_line,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_report_kind,
  input  logic [1:0] out_bracket_type,
  input  logic       out_last_result,
  output int         error_count,
  output int         reports_due
);
  import bbc_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] btype;
    logic       last;
  } report_t;

  logic [1:0]  open_types [STACK_DEPTH];
  int unsigned open_count;
  logic        line_ok;
  report_t     due_q [$];

  task automatic push_open(input logic [1:0] t);
    // a full stack drops the bracket without a trace
    if (open_count < STACK_DEPTH) begin
      open_types[open_count] = t;
      open_count++;
    end
  endtask

  task automatic pop_close(input logic [1:0] t);
    if (open_count == 0) begin
      due_q.push_back('{KIND_CLOSE, t, 1'b1});
      line_ok = 1'b0;
    end else begin
      open_count--;
      if (open_types[open_count] != t) line_ok = 1'b0;
    end
  endtask

  task automatic predict_reports(input logic [7:0] c, input logic eol);
    if (eol) begin
      if (line_ok && open_count == 0) begin
        due_q.push_back('{KIND_OK, TYPE_ROUND, 1'b1});
      end else begin
        due_q.push_back('{KIND_FAIL, TYPE_ROUND, open_count == 0});
        // leftover opens come out top first
        while (open_count > 0) begin
          open_count--;
          due_q.push_back('{KIND_OPEN, open_types[open_count], open_count == 0});
        end
      end
      open_count = 0;
      line_ok = 1'b1;
    end else begin
      case (c)
        CH_OPEN_ROUND:   push_open(TYPE_ROUND);
        CH_OPEN_SQUARE:  push_open(TYPE_SQUARE);
        CH_OPEN_CURLY:   push_open(TYPE_CURLY);
        CH_CLOSE_ROUND:  pop_close(TYPE_ROUND);
        CH_CLOSE_SQUARE: pop_close(TYPE_SQUARE);
        CH_CLOSE_CURLY:  pop_close(TYPE_CURLY);
        default: ;
      endcase
    end
  endtask

  task automatic check_report();
    report_t want;
    report_t got;
    got = '{out_report_kind, out_bracket_type, out_last_result};
    if (due_q.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result kind=%0d type=%0d last=%0b",
               $time, got.kind, got.btype, got.last);
    end else begin
      want = due_q.pop_front();
      if (got !== want) begin
        error_count++;
        $display("%0t: mismatch expected kind=%0d type=%0d last=%0b, got kind=%0d type=%0d last=%0b",
                 $time, want.kind, want.btype, want.last, got.kind, got.btype, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      open_count = 0;
      line_ok = 1'b1;
      due_q.delete();
    end else begin
      if (in_valid && in_ready) predict_reports(in_char_code, in_end_of_line);
      if (out_valid && out_ready) check_report();
    end
    reports_due <= due_q.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import bbc_pkg::*;

  localparam int ITEM_TARGET = 380;

  // receiver stall patterns
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_COIN   = 1;
  localparam int RDY_SLOW   = 2;
  localparam int RDY_PULSED = 3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char_code = '0;
  logic       in_end_of_line = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_report_kind;
  logic [1:0] out_bracket_type;
  logic       out_last_result;

  int error_count;
  int reports_due;
  int item_count = 0;
  int burst_left = 0;
  int ready_mode = RDY_ALWAYS;
  int ready_phase = 0;
  int pick;
  logic [7:0] line_buf [$];

  bracket_balance_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_report_kind  (out_report_kind),
    .out_bracket_type (out_bracket_type),
    .out_last_result  (out_last_result)
  );

  bbc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_report_kind  (out_report_kind),
    .out_bracket_type (out_bracket_type),
    .out_last_result  (out_last_result),
    .error_count      (error_count),
    .reports_due      (reports_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode <= $urandom_range(RDY_ALWAYS, RDY_PULSED);
      ready_phase <= $urandom_range(8, 80);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= $urandom_range(0, 1);
      RDY_SLOW:   out_ready <= ($urandom_range(0, 4) == 0);
      default:    out_ready <= (ready_phase[2:0] == 3'd0);
    endcase
  end

  function automatic logic [1:0] rand_type();
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] open_char(input logic [1:0] t);
    case (t)
      TYPE_ROUND:  return CH_OPEN_ROUND;
      TYPE_SQUARE: return CH_OPEN_SQUARE;
      default:     return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input logic [1:0] t);
    case (t)
      TYPE_ROUND:  return CH_CLOSE_ROUND;
      TYPE_SQUARE: return CH_CLOSE_SQUARE;
      default:     return CH_CLOSE_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] any_bracket();
    return $urandom_range(0, 1) ? open_char(rand_type()) : close_char(rand_type());
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_line <= eol;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    item_count++;
  endtask

  // the character sent with end of line is random, the block ignores it
  task automatic flush_line();
    foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
    send_char(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  task automatic make_nested_line();
    logic [1:0] open_q [$];
    logic [1:0] t;
    int steps;
    int r;
    int idx;
    steps = $urandom_range(0, 24);
    repeat (steps) begin
      r = $urandom_range(0, 9);
      if (r < 4 && open_q.size() < 12) begin
        t = rand_type();
        open_q.push_back(t);
        line_buf.push_back(open_char(t));
      end else if (r < 8 && open_q.size() > 0) begin
        line_buf.push_back(close_char(open_q.pop_back()));
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      while (open_q.size() > 0) line_buf.push_back(close_char(open_q.pop_back()));
    end
    // break some lines on purpose
    if ($urandom_range(0, 3) == 0 && line_buf.size() > 0) begin
      idx = $urandom_range(0, line_buf.size() - 1);
      line_buf[idx] = any_bracket();
    end
    flush_line();
  endtask

  task automatic make_mixed_line();
    repeat ($urandom_range(0, 12)) begin
      line_buf.push_back($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
    end
    flush_line();
  endtask

  // runs past the stack limit now and then
  task automatic make_deep_line();
    repeat ($urandom_range(28, 40)) line_buf.push_back(open_char(rand_type()));
    repeat ($urandom_range(0, 3)) line_buf.push_back(any_bracket());
    flush_line();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty line, simple and nested balanced lines with noise bytes
    flush_line();
    line_buf = '{CH_OPEN_ROUND, CH_CLOSE_ROUND};
    flush_line();
    line_buf = '{CH_OPEN_SQUARE, 8'h00, CH_OPEN_CURLY, 8'hFF, CH_CLOSE_CURLY, CH_CLOSE_SQUARE};
    flush_line();
    // closes on an empty stack
    line_buf = '{CH_CLOSE_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY};
    flush_line();
    // type mismatch
    line_buf = '{CH_OPEN_ROUND, CH_CLOSE_SQUARE};
    flush_line();
    // unmatched opens, end of line carrying a bracket that must be ignored
    send_char(CH_OPEN_CURLY, 1'b0);
    send_char(CH_OPEN_SQUARE, 1'b0);
    send_char(CH_OPEN_ROUND, 1'b0);
    send_char(CH_OPEN_ROUND, 1'b1);

    while (item_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) make_nested_line();
      else if (pick < 18) make_mixed_line();
      else make_deep_line();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (reports_due != 0);
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_front.sv
rtl/bbc_fifo.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
rtl/bbc_checker.sv
verif/bbc_checker.sv
verif/tb_top.sv
